### src/cfa_pkg.sv
// shared types and constants for the contiguous fit allocator
// no dependencies; used by cfa_run_tracker and contiguous_fit_allocator_top
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

    // request operation codes
    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_BEST  = 2'd1,
        OP_WORST = 2'd2,
        OP_FREE  = 2'd3
    } op_t;

    // fixed widths of the request and result fields
    localparam int OPCODE_BITS = 2;
    localparam int OWNER_BITS  = 8;
    localparam int NEED_BITS   = 8;
    localparam int START_BITS  = 7;

    // control from the sequencer to the run tracker
    typedef struct packed {
        logic clear;
        logic step;
        logic cell_free;
        op_t  policy;
    } trk_ctrl_t;

endpackage

`default_nettype wire

### src/contiguous_fit_allocator_top.sv
// contiguous fit allocator top: owner table memory and request sequencer
// depends on cfa_pkg and cfa_run_tracker
`timescale 1ns / 1ps
`default_nettype none

// usage
// - a request is taken on a rising edge with start high and busy low:
//   opcode picks first, best or worst fit allocation, or free of an owner
// - the owner table sits in one synchronous memory (one write port, one
//   read port, read data registered), so scans and frees walk the cells
//   one per cycle through that read port
// - allocation: a scan finds the run, S_PICK settles the pick, then S_FILL
//   tags the run, one cell per cycle
// - free: the read of cell k overlaps the write-back of cell k-1
// - an allocation with a zero or oversized size, or the empty code as
//   owner, is answered on the next cycle without touching the table
// - the result (success, start_cell) is shown for exactly one cycle with
//   done high, in the cycle busy falls; a new request may be taken then
// - the receiver cannot stall, so nothing backs up on the result side
// - after reset a clearing pass writes the empty code to every cell;
//   busy stays high until it ends
// - one request is in flight at a time
module contiguous_fit_allocator_top #(
    parameter int CELLS   = 128,
    parameter int ID_BITS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [cfa_pkg::OPCODE_BITS-1:0] opcode,
    input  wire logic [cfa_pkg::OWNER_BITS-1:0]  owner_id,
    input  wire logic [cfa_pkg::NEED_BITS-1:0]   request_cells,
    output logic                                 done,
    output logic                                 success,
    output logic [cfa_pkg::START_BITS-1:0]       start_cell
);

    localparam int AW = $clog2(CELLS);
    localparam int LW = $clog2(CELLS + 1);
    localparam int SW = $clog2(CELLS + 2);
    localparam int SB = cfa_pkg::START_BITS;
    localparam logic [ID_BITS-1:0] EMPTY_ID = {ID_BITS{1'b1}};

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FREE  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_PICK  = 6'b010000,
        S_FILL  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [SW-1:0]        idx_reg, idx_next;
    cfa_pkg::op_t         op_reg, op_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [LW-1:0]        need_reg, need_next;
    logic [AW-1:0]        fill_addr_reg, fill_addr_next;
    logic [LW-1:0]        fill_left_reg, fill_left_next;
    logic                 done_reg, done_next;
    logic                 success_reg, success_next;
    logic [SB-1:0]        start_reg, start_next;

    // owner table memory
    logic [ID_BITS-1:0]   owner_mem [CELLS];
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [ID_BITS-1:0]   rd_data_reg;
    logic                 we;
    logic [AW-1:0]        wr_addr;
    logic [ID_BITS-1:0]   wr_data;

    // run tracker
    cfa_pkg::trk_ctrl_t   trk_ctrl;
    logic                 trk_found;
    logic [AW-1:0]        trk_pick;

    logic [ID_BITS-1:0]   req_id;
    logic                 accept;
    logic                 req_bad;
    logic [AW-1:0]        prev_cell;

    assign req_id    = ID_BITS'(owner_id);
    assign accept    = start && (state_reg == S_IDLE);
    assign req_bad   = (request_cells == '0) || (int'(request_cells) > CELLS)
                       || (req_id == EMPTY_ID);
    // cell whose data arrives this cycle
    assign prev_cell = AW'(idx_reg - SW'(1));

    cfa_run_tracker #(
        .CELLS (CELLS)
    ) u_run_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (trk_ctrl),
        .cell_idx (prev_cell),
        .need     (need_reg),
        .found    (trk_found),
        .pick     (trk_pick)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        need_next      = need_reg;
        fill_addr_next = fill_addr_reg;
        fill_left_next = fill_left_reg;
        done_next      = 1'b0;
        success_next   = success_reg;
        start_next     = start_reg;
        rd_en          = 1'b0;
        rd_addr        = AW'(idx_reg);
        we             = 1'b0;
        wr_addr        = AW'(idx_reg);
        wr_data        = EMPTY_ID;
        trk_ctrl.clear     = 1'b0;
        trk_ctrl.step      = 1'b0;
        trk_ctrl.cell_free = 1'b0;
        trk_ctrl.policy    = op_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // write the empty code to every cell
                we       = 1'b1;
                idx_next = idx_reg + SW'(1);
                if (idx_reg == SW'(CELLS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = cfa_pkg::op_t'(opcode);
                    id_next   = req_id;
                    need_next = LW'(request_cells);
                    idx_next  = '0;
                    trk_ctrl.clear = 1'b1;
                    if (cfa_pkg::op_t'(opcode) == cfa_pkg::OP_FREE)
                        state_next = S_FREE;
                    else if (req_bad)
                    begin
                        done_next    = 1'b1;
                        success_next = 1'b0;
                        start_next   = '0;
                    end
                    else
                        state_next = S_SCAN;
                end
            end
            S_FREE:
            begin
                // read cell k while writing back cell k-1
                rd_en    = (idx_reg < SW'(CELLS));
                we       = (idx_reg != '0) && (rd_data_reg == id_reg);
                wr_addr  = prev_cell;
                idx_next = idx_reg + SW'(1);
                if (idx_reg == SW'(CELLS))
                begin
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    success_next = 1'b1;
                    start_next   = '0;
                end
            end
            S_SCAN:
            begin
                // the step past the last cell closes any open run
                rd_en              = (idx_reg < SW'(CELLS));
                trk_ctrl.step      = (idx_reg != '0);
                trk_ctrl.cell_free = (idx_reg <= SW'(CELLS)) && (rd_data_reg == EMPTY_ID);
                idx_next           = idx_reg + SW'(1);
                if (idx_reg == SW'(CELLS + 1))
                    state_next = S_PICK;
            end
            S_PICK:
            begin
                if (trk_found)
                begin
                    fill_addr_next = trk_pick;
                    fill_left_next = need_reg;
                    state_next     = S_FILL;
                end
                else
                begin
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    success_next = 1'b0;
                    start_next   = '0;
                end
            end
            S_FILL:
            begin
                we             = 1'b1;
                wr_addr        = fill_addr_reg;
                wr_data        = id_reg;
                fill_addr_next = fill_addr_reg + AW'(1);
                fill_left_next = fill_left_reg - LW'(1);
                if (fill_left_reg == LW'(1))
                begin
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    success_next = 1'b1;
                    start_next   = SB'(trk_pick);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        need_reg      <= need_next;
        fill_addr_reg <= fill_addr_next;
        fill_left_reg <= fill_left_next;
        success_reg   <= success_next;
        start_reg     <= start_next;
    end

    // owner table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            owner_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= owner_mem[rd_addr];
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign success    = success_reg;
    assign start_cell = start_reg;

    // a result is only shown as the sequencer returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    // a failed request reports start cell zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !success_reg) |-> (start_reg == '0))
        else $error("failed request with nonzero start");

    // the table is never written while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !we)
        else $error("table write while idle");

    // tagging only runs with cells left to tag
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (fill_left_reg != '0))
        else $error("fill with no cells left");

    // a rejected request is answered on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode != cfa_pkg::OP_FREE) && req_bad) |=> (done_reg && !success_reg))
        else $error("rejected request not answered at once");

endmodule

`default_nettype wire

### src/cfa_run_tracker.sv
// free run tracker: follows runs of empty cells during a scan and keeps
// the pick for first, best or worst fit; depends on cfa_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfa_run_tracker #(
    parameter int CELLS = 128
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cfa_pkg::trk_ctrl_t           ctrl,
    input  wire logic [$clog2(CELLS)-1:0]     cell_idx,
    input  wire logic [$clog2(CELLS+1)-1:0]   need,
    output logic                              found,
    output logic [$clog2(CELLS)-1:0]          pick
);

    localparam int AW = $clog2(CELLS);
    localparam int LW = $clog2(CELLS + 1);

    logic [AW-1:0] run_start_reg, run_start_next;
    logic [LW-1:0] run_len_reg, run_len_next;
    logic          found_reg, found_next;
    logic [AW-1:0] pick_reg, pick_next;
    logic [LW-1:0] pick_len_reg, pick_len_next;

    always_comb
    begin
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_len_next  = pick_len_reg;
        if (ctrl.clear)
        begin
            run_len_next  = '0;
            found_next    = 1'b0;
            pick_next     = '0;
            pick_len_next = '0;
        end
        else if (ctrl.step)
        begin
            if (ctrl.cell_free)
            begin
                if (run_len_reg == '0)
                    run_start_next = cell_idx;
                run_len_next = run_len_reg + LW'(1);
            end
            else
            begin
                // a run just ended; weigh it against the current pick
                if (run_len_reg >= need)
                begin
                    if (!found_reg)
                    begin
                        found_next    = 1'b1;
                        pick_next     = run_start_reg;
                        pick_len_next = run_len_reg;
                    end
                    else if (ctrl.policy == cfa_pkg::OP_BEST && run_len_reg < pick_len_reg)
                    begin
                        pick_next     = run_start_reg;
                        pick_len_next = run_len_reg;
                    end
                    else if (ctrl.policy == cfa_pkg::OP_WORST && run_len_reg > pick_len_reg)
                    begin
                        pick_next     = run_start_reg;
                        pick_len_next = run_len_reg;
                    end
                end
                run_len_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_start_reg <= '0;
            run_len_reg   <= '0;
            found_reg     <= 1'b0;
            pick_reg      <= '0;
            pick_len_reg  <= '0;
        end
        else
        begin
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            found_reg     <= found_next;
            pick_reg      <= pick_next;
            pick_len_reg  <= pick_len_next;
        end
    end

    assign found = found_reg;
    assign pick  = pick_reg;

endmodule

`default_nettype wire

### verif/contiguous_fit_allocator_top_test.sv
// self-checking testbench for contiguous_fit_allocator_top: directed and random requests
// checked against an owner map kept in step inside the bench; depends on cfa_pkg
`timescale 1ns / 1ps

module contiguous_fit_allocator_top_test;

    localparam int OWNER_BITS      = cfa_pkg::OWNER_BITS;
    localparam int NEED_BITS       = cfa_pkg::NEED_BITS;
    localparam int START_BITS      = cfa_pkg::START_BITS;
    localparam int NUM_CELLS       = 128;
    localparam logic [OWNER_BITS-1:0] EMPTY_ID = '1;
    localparam int SETTLE_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int REPORT_LIMIT    = 10;

    // one result as the allocator reports it
    typedef struct packed {
        logic                  success;
        logic [START_BITS-1:0] start_cell;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    cfa_pkg::op_t          opcode = cfa_pkg::OP_FIRST;
    logic [OWNER_BITS-1:0] owner_id = '0;
    logic [NEED_BITS-1:0]  request_cells = '0;
    logic                  busy;
    logic                  done;
    logic                  success;
    logic [START_BITS-1:0] start_cell;

    // bench copy of the owner table, updated as each request is taken
    logic [OWNER_BITS-1:0] owner_map [NUM_CELLS];
    // results still to come, oldest first
    outcome_t              outcomes_due [$];
    outcome_t              head_outcome;
    int                    mismatch_count = 0;
    int                    sender_idle_pct = 0;
    int                    quiet_cycles = 0;

    contiguous_fit_allocator_top #(
        .CELLS   (NUM_CELLS),
        .ID_BITS (OWNER_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .owner_id      (owner_id),
        .request_cells (request_cells),
        .done          (done),
        .success       (success),
        .start_cell    (start_cell)
    );

    always #6 clk = ~clk;

    // work out the result of one request and apply it to the owner map
    function automatic outcome_t serve_request(cfa_pkg::op_t op,
                                               logic [OWNER_BITS-1:0] id,
                                               logic [NEED_BITS-1:0] cells);
        outcome_t res;
        int       k;
        int       run_from;
        int       run_len;
        int       pick;
        int       pick_len;
        bit       found;
        bit       cell_empty;
        res = '0;
        if (op == cfa_pkg::OP_FREE)
        begin
            // free always reports success, even when nothing carries the id
            for (k = 0; k < NUM_CELLS; k++)
            begin
                if (owner_map[k] == id)
                    owner_map[k] = EMPTY_ID;
            end
            res.success = 1'b1;
            return res;
        end
        // zero or oversized size, or the empty code as owner: refused
        if (cells == 0 || cells > NUM_CELLS || id == EMPTY_ID)
            return res;
        found    = 1'b0;
        pick     = 0;
        pick_len = 0;
        run_from = 0;
        run_len  = 0;
        // one position past the end closes the last run
        for (k = 0; k <= NUM_CELLS; k++)
        begin
            cell_empty = 1'b0;
            if (k < NUM_CELLS)
                cell_empty = (owner_map[k] == EMPTY_ID);
            if (cell_empty)
            begin
                if (run_len == 0)
                    run_from = k;
                run_len++;
            end
            else
            begin
                // the whole run must cover the size; ties keep the earlier run
                if (run_len >= cells)
                begin
                    if (!found
                        || (op == cfa_pkg::OP_BEST && run_len < pick_len)
                        || (op == cfa_pkg::OP_WORST && run_len > pick_len))
                    begin
                        found    = 1'b1;
                        pick     = run_from;
                        pick_len = run_len;
                    end
                end
                run_len = 0;
            end
        end
        if (!found)
            return res;
        for (k = pick; k < pick + cells; k++)
            owner_map[k] = id;
        res.success    = 1'b1;
        res.start_cell = START_BITS'(pick);
        return res;
    endfunction

    function automatic void log_mismatch(string what, int unsigned want, int unsigned got);
        if (mismatch_count < REPORT_LIMIT)
            $display("mismatch: %s expected %0d got %0d", what, want, got);
        mismatch_count++;
    endfunction

    // send one request; start stays high afterwards so a following request
    // can go out back to back
    task automatic send_request(cfa_pkg::op_t op, logic [OWNER_BITS-1:0] id,
                                logic [NEED_BITS-1:0] cells);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        start         <= 1'b1;
        opcode        <= op;
        owner_id      <= id;
        request_cells <= cells;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        outcomes_due.push_back(serve_request(op, id, cells));
    endtask

    // hold off new requests until every result has come back
    task automatic wait_until_drained();
        start <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // free owners one at a time until the whole store is empty
    task automatic release_all_owners();
        logic [OWNER_BITS-1:0] victim;
        int                    k;
        forever
        begin
            victim = EMPTY_ID;
            for (k = 0; k < NUM_CELLS && victim == EMPTY_ID; k++)
                victim = owner_map[k];
            if (victim == EMPTY_ID)
                break;
            // the size field is ignored for free, so give it noise
            send_request(cfa_pkg::OP_FREE, victim, NEED_BITS'($urandom_range(255)));
        end
    endtask

    // requests that must be refused or that change nothing
    task automatic test_rejected_requests();
        send_request(cfa_pkg::OP_FIRST, 8'd3, 8'd0);
        send_request(cfa_pkg::OP_BEST, 8'd4, 8'd129);
        send_request(cfa_pkg::OP_WORST, 8'd5, 8'd255);
        // empty code as owner would leave an unreadable tag
        send_request(cfa_pkg::OP_FIRST, EMPTY_ID, 8'd4);
        send_request(cfa_pkg::OP_FREE, EMPTY_ID, 8'd0);
        send_request(cfa_pkg::OP_FREE, 8'd7, 8'd12);
        wait_until_drained();
    endtask

    // the largest request fills the store, after which nothing fits
    task automatic test_whole_store();
        send_request(cfa_pkg::OP_FIRST, 8'd0, 8'd128);
        send_request(cfa_pkg::OP_BEST, 8'd1, 8'd1);
        send_request(cfa_pkg::OP_FREE, 8'd0, 8'd0);
        wait_until_drained();
    endtask

    // a fragmented store: ties, largest and smallest runs, and a first fit
    // that has to skip a run too short for it
    task automatic test_fit_policies();
        send_request(cfa_pkg::OP_FIRST, 8'd1, 8'd3);
        send_request(cfa_pkg::OP_FIRST, 8'd2, 8'd4);
        send_request(cfa_pkg::OP_FIRST, 8'd3, 8'd2);
        send_request(cfa_pkg::OP_FIRST, 8'd4, 8'd4);
        send_request(cfa_pkg::OP_FIRST, 8'd5, 8'd115);
        // two free runs of four cells at 3 and 9
        send_request(cfa_pkg::OP_FREE, 8'd2, 8'd0);
        send_request(cfa_pkg::OP_FREE, 8'd4, 8'd0);
        // best fit tie takes the earlier run
        send_request(cfa_pkg::OP_BEST, 8'd6, 8'd1);
        // worst fit takes the larger, later run
        send_request(cfa_pkg::OP_WORST, 8'd7, 8'd1);
        // worst fit tie between two runs of three
        send_request(cfa_pkg::OP_WORST, 8'd8, 8'd1);
        // first fit has to pass over the two-cell run at 5
        send_request(cfa_pkg::OP_FIRST, 8'd9, 8'd3);
        // no run left that fits
        send_request(cfa_pkg::OP_BEST, 8'd10, 8'd3);
        wait_until_drained();
        release_all_owners();
        wait_until_drained();
    endtask

    // mostly well-formed allocations and frees of live owners, with some noise
    task automatic test_random_traffic(int idle_pct, int count);
        int                    n;
        int                    roll;
        int                    k;
        int                    offset;
        logic [OWNER_BITS-1:0] victim;
        logic [NEED_BITS-1:0]  cells;
        sender_idle_pct = idle_pct;
        for (n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            victim = EMPTY_ID;
            if (roll >= 8 && roll < 35)
            begin
                // look for a live owner from a random place in the store
                offset = $urandom_range(NUM_CELLS - 1);
                for (k = 0; k < NUM_CELLS && victim == EMPTY_ID; k++)
                    victim = owner_map[(offset + k) % NUM_CELLS];
            end
            if (roll < 8)
            begin
                case ($urandom_range(3))
                    0: send_request(cfa_pkg::op_t'($urandom_range(2)),
                                    OWNER_BITS'($urandom_range(254)), 8'd0);
                    1: send_request(cfa_pkg::op_t'($urandom_range(2)),
                                    OWNER_BITS'($urandom_range(254)),
                                    NEED_BITS'($urandom_range(255, 129)));
                    2: send_request(cfa_pkg::op_t'($urandom_range(2)), EMPTY_ID,
                                    NEED_BITS'($urandom_range(128, 1)));
                    default: send_request(cfa_pkg::OP_FREE,
                                          OWNER_BITS'($urandom_range(255)),
                                          NEED_BITS'($urandom_range(255)));
                endcase
            end
            else if (victim != EMPTY_ID)
                send_request(cfa_pkg::OP_FREE, victim, NEED_BITS'($urandom_range(255)));
            else
            begin
                // mostly small runs so the store fragments without filling
                roll = $urandom_range(99);
                if (roll < 80)
                    cells = NEED_BITS'($urandom_range(16, 1));
                else if (roll < 95)
                    cells = NEED_BITS'($urandom_range(64, 17));
                else
                    cells = NEED_BITS'($urandom_range(128, 65));
                send_request(cfa_pkg::op_t'($urandom_range(2)),
                             OWNER_BITS'($urandom_range(254)), cells);
            end
        end
        wait_until_drained();
    endtask

    // result checker: every strobe is matched against the oldest request
    always @(posedge clk)
    begin
        if (rst_n && done !== 1'b0)
        begin
            if (outcomes_due.size() == 0)
                log_mismatch("result with no request waiting, done", 0, done);
            else
            begin
                head_outcome = outcomes_due.pop_front();
                if (success !== head_outcome.success)
                    log_mismatch("success", head_outcome.success, success);
                if (start_cell !== head_outcome.start_cell)
                    log_mismatch("start_cell", head_outcome.start_cell, start_cell);
            end
        end
    end

    // watchdog: too long without a request taken or a result given
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        foreach (owner_map[k])
            owner_map[k] = EMPTY_ID;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // busy covers the clearing pass, so the first request simply waits
        test_rejected_requests();
        test_whole_store();
        test_fit_policies();
        test_random_traffic(10, 600);
        release_all_owners();
        test_random_traffic(80, 600);
        release_all_owners();
        test_random_traffic(0, 600);
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
